// File: src/box_sprite_mover_and_compositor_defines.svh
// Assertion macros used by the RTL of the sprite mover and compositor.
`ifndef BOX_SPRITE_MOVER_AND_COMPOSITOR_DEFINES_SVH
`define BOX_SPRITE_MOVER_AND_COMPOSITOR_DEFINES_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define BSM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define BSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BSM_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define BSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/bsm_pkg.sv
package bsm_pkg;

  // Fixed field widths.
  localparam int COLOR_W = 16;
  localparam int WHO_W   = 3;
  localparam int PIX_W   = 9;
  localparam int REG_COUNT = 5;
  localparam int ADDR_W  = 5;

  // Defaults for the top-level parameters.
  localparam int SPRITE_COUNT_DEF  = 4;
  localparam int BOX_EDGE_DEF      = 30;
  localparam int SCREEN_WIDTH_DEF  = 480;
  localparam int SCREEN_HEIGHT_DEF = 320;

  // Item opcodes.
  localparam logic OP_MOVE  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SPRITE0    = 3'd0;
  localparam logic [2:0] REG_SPRITE1    = 3'd1;
  localparam logic [2:0] REG_SPRITE2    = 3'd2;
  localparam logic [2:0] REG_SPRITE3    = 3'd3;
  localparam logic [2:0] REG_BACKGROUND = 3'd4;

  // Colors in panel order before the byte swap.
  localparam logic [15:0] COLOR_RED     = 16'hF800;
  localparam logic [15:0] COLOR_GREEN   = 16'h07E0;
  localparam logic [15:0] COLOR_BLUE    = 16'h001F;
  localparam logic [15:0] COLOR_YELLOW  = 16'hFFE0;
  localparam logic [15:0] COLOR_BACKGND = 16'h18C3;

  typedef struct packed {
    logic                    opcode;
    logic [1:0]              sprite_id;
    logic signed [7:0]       delta_x;
    logic signed [7:0]       delta_y;
    logic [PIX_W-1:0]        pixel_x;
    logic [PIX_W-1:0]        pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [WHO_W-1:0]   covering_sprite;
  } out_item_t;

  // What travels from one cell to the next: the item and the best hit so far.
  typedef struct packed {
    in_item_t           item;
    logic [COLOR_W-1:0] color;
    logic [WHO_W-1:0]   who;
  } stage_t;

  // Swap the two bytes of a color for the panel.
  function automatic logic [15:0] panel_swap(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  // Reset colors of the four sprite color registers.
  function automatic logic [15:0] sprite_color_reset(input int idx);
    logic [15:0] c;
    case (idx)
      0:       c = COLOR_RED;
      1:       c = COLOR_GREEN;
      2:       c = COLOR_BLUE;
      default: c = COLOR_YELLOW;
    endcase
    return panel_swap(c);
  endfunction

  // Reset positions; sprites past the fourth start at the origin.
  function automatic int left_reset(input int idx);
    int v;
    case (idx)
      0:       v = 50;
      1:       v = 400;
      2:       v = 220;
      3:       v = 100;
      default: v = 0;
    endcase
    return v;
  endfunction

  function automatic int top_reset(input int idx);
    int v;
    case (idx)
      0:       v = 60;
      1:       v = 60;
      2:       v = 20;
      3:       v = 200;
      default: v = 0;
    endcase
    return v;
  endfunction

  // Position width: enough for either screen axis and for the reset positions.
  function automatic int pos_width(input int w, input int h);
    int r;
    r = 9;
    if ($clog2(w) > r) r = $clog2(w);
    if ($clog2(h) > r) r = $clog2(h);
    return r;
  endfunction

endpackage

// File: src/box_sprite_mover_and_compositor.sv
// An accepted pixel item passes through one register per cell; the last is the result register.
// Throughput: one item per cycle; each cell tests one sprite box, and the chain moves
// forward whenever the result register is empty or being taken.
// Move items pass through the chain and give no result.
// Reset (synchronous, rst_n low) restores sprite positions and colors and empties the chain.
`include "box_sprite_mover_and_compositor_defines.svh"

module box_sprite_mover_and_compositor #(
  parameter int SPRITE_COUNT  = bsm_pkg::SPRITE_COUNT_DEF,
  parameter int BOX_EDGE      = bsm_pkg::BOX_EDGE_DEF,
  parameter int SCREEN_WIDTH  = bsm_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = bsm_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bsm_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bsm_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [bsm_pkg::COLOR_W-1:0] color_r [4];
  logic [bsm_pkg::COLOR_W-1:0] bg_r;
  logic [2:0]                  reg_idx;
  logic                        cfg_write;
  logic                        advance;
  logic [SPRITE_COUNT:0]       valid_w;
  bsm_pkg::stage_t             stage_w [SPRITE_COUNT+1];

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        color_r[i] <= bsm_pkg::sprite_color_reset(i);
      end
      bg_r <= bsm_pkg::panel_swap(bsm_pkg::COLOR_BACKGND);
    end else if (cfg_write) begin
      case (reg_idx)
        bsm_pkg::REG_SPRITE0:    color_r[0] <= pwdata[15:0];
        bsm_pkg::REG_SPRITE1:    color_r[1] <= pwdata[15:0];
        bsm_pkg::REG_SPRITE2:    color_r[2] <= pwdata[15:0];
        bsm_pkg::REG_SPRITE3:    color_r[3] <= pwdata[15:0];
        bsm_pkg::REG_BACKGROUND: bg_r       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bsm_pkg::REG_SPRITE0:    prdata = {16'h0000, color_r[0]};
      bsm_pkg::REG_SPRITE1:    prdata = {16'h0000, color_r[1]};
      bsm_pkg::REG_SPRITE2:    prdata = {16'h0000, color_r[2]};
      bsm_pkg::REG_SPRITE3:    prdata = {16'h0000, color_r[3]};
      bsm_pkg::REG_BACKGROUND: prdata = {16'h0000, bg_r};
      default:                 prdata = '0;
    endcase
  end

  // The whole chain moves unless a finished result is held up.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // An item enters with the background as its provisional answer.
  assign valid_w[0]          = in_valid;
  assign stage_w[0].item     = in_item;
  assign stage_w[0].color    = bg_r;
  assign stage_w[0].who      = bsm_pkg::WHO_W'(SPRITE_COUNT);

  // One cell per sprite.
  for (genvar g = 0; g < SPRITE_COUNT; g++) begin : g_cell
    bsm_cell #(
      .INDEX         (g),
      .BOX_EDGE      (BOX_EDGE),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .in_valid  (valid_w[g]),
      .in_stage  (stage_w[g]),
      .color     (color_r[g % 4]),
      .out_valid (valid_w[g+1]),
      .out_stage (stage_w[g+1])
    );
  end

  // The last cell's register is the result register; only pixel items show.
  assign out_valid = valid_w[SPRITE_COUNT] &&
                     (stage_w[SPRITE_COUNT].item.opcode == bsm_pkg::OP_PIXEL);
  assign out_item.pixel_color     = stage_w[SPRITE_COUNT].color;
  assign out_item.covering_sprite = stage_w[SPRITE_COUNT].who;

  // A held result freezes every stage of the chain.
  `BSM_ASSERT_NEXT(a_hold_chain, clk, rst_n, !advance, $stable(valid_w[SPRITE_COUNT:1]))
  // A pixel past the right edge of the screen always resolves to the background.
  `BSM_ASSERT_SAME(a_off_screen, clk, rst_n,
    out_valid && (int'(stage_w[SPRITE_COUNT].item.pixel_x) >= SCREEN_WIDTH),
    out_item.covering_sprite == bsm_pkg::WHO_W'(SPRITE_COUNT))
  // The background code carries the background color.
  `BSM_ASSERT_SAME(a_bg_color, clk, rst_n,
    out_valid && (SPRITE_COUNT < 8) &&
    (out_item.covering_sprite == bsm_pkg::WHO_W'(SPRITE_COUNT)),
    out_item.pixel_color == bg_r)

endmodule

// File: src/bsm_cell.sv
module bsm_cell #(
  parameter int INDEX         = 0,
  parameter int BOX_EDGE      = bsm_pkg::BOX_EDGE_DEF,
  parameter int SCREEN_WIDTH  = bsm_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = bsm_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic                         in_valid,
  input  bsm_pkg::stage_t              in_stage,
  input  logic [bsm_pkg::COLOR_W-1:0]  color,
  output logic                         out_valid,
  output bsm_pkg::stage_t              out_stage
);

  localparam int POS_W = bsm_pkg::pos_width(SCREEN_WIDTH, SCREEN_HEIGHT);
  localparam int SUM_W = POS_W + 2;
  localparam logic signed [SUM_W-1:0] WIDTH_S  = SUM_W'(SCREEN_WIDTH);
  localparam logic signed [SUM_W-1:0] HEIGHT_S = SUM_W'(SCREEN_HEIGHT);
  localparam logic signed [SUM_W-1:0] EDGE_S   = SUM_W'(BOX_EDGE);

  logic [POS_W-1:0] left_r, left_nxt;
  logic [POS_W-1:0] top_r, top_nxt;
  logic             valid_r;
  bsm_pkg::stage_t  stage_r, stage_nxt;
  logic             is_move;
  logic             hit;
  logic [SUM_W-1:0] px, py, lx, ty;

  // Add a signed step and wrap to the screen on one axis.
  function automatic logic [POS_W-1:0] wrap_axis(
    input logic [POS_W-1:0]        pos,
    input logic signed [7:0]       delta,
    input logic signed [SUM_W-1:0] size
  );
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        r;
    sum = $signed({2'b00, pos}) + SUM_W'(delta);
    if (sum >= size) begin
      r = '0;
    end else if (sum < 0) begin
      r = POS_W'(size - EDGE_S);
    end else begin
      r = sum[POS_W-1:0];
    end
    return r;
  endfunction

  // Position update when a move for this sprite passes by.
  assign is_move = in_valid && (in_stage.item.opcode == bsm_pkg::OP_MOVE) &&
                   (int'(in_stage.item.sprite_id) == INDEX);

  always_comb begin
    left_nxt = left_r;
    top_nxt  = top_r;
    if (is_move) begin
      left_nxt = wrap_axis(left_r, in_stage.item.delta_x, WIDTH_S);
      top_nxt  = wrap_axis(top_r, in_stage.item.delta_y, HEIGHT_S);
    end
  end

  // Coverage test of the queried pixel against this sprite's box.
  assign px = SUM_W'(in_stage.item.pixel_x);
  assign py = SUM_W'(in_stage.item.pixel_y);
  assign lx = SUM_W'(left_r);
  assign ty = SUM_W'(top_r);

  assign hit = (px < SUM_W'(SCREEN_WIDTH)) && (py < SUM_W'(SCREEN_HEIGHT)) &&
               (px >= lx) && (px < lx + SUM_W'(BOX_EDGE)) &&
               (py >= ty) && (py < ty + SUM_W'(BOX_EDGE));

  // A later sprite overrides whatever earlier cells chose.
  always_comb begin
    stage_nxt = in_stage;
    if ((in_stage.item.opcode == bsm_pkg::OP_PIXEL) && hit) begin
      stage_nxt.color = color;
      stage_nxt.who   = bsm_pkg::WHO_W'(INDEX);
    end
  end

  // Sprite position, held by this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= POS_W'(bsm_pkg::left_reset(INDEX));
      top_r  <= POS_W'(bsm_pkg::top_reset(INDEX));
    end else if (advance) begin
      left_r <= left_nxt;
      top_r  <= top_nxt;
    end
  end

  // Item register toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

// File: sim/box_sprite_mover_and_compositor_test.sv
`timescale 1ns / 1ps

module box_sprite_mover_and_compositor_test;

  localparam int SPRITES  = bsm_pkg::SPRITE_COUNT_DEF;
  localparam int EDGE_LEN = bsm_pkg::BOX_EDGE_DEF;
  localparam int SCR_W    = bsm_pkg::SCREEN_WIDTH_DEF;
  localparam int SCR_H    = bsm_pkg::SCREEN_HEIGHT_DEF;

  // Colors held by the registers after reset, already in panel byte order.
  localparam logic [15:0] COLOR0_RESET = 16'h00F8;
  localparam logic [15:0] COLOR1_RESET = 16'hE007;
  localparam logic [15:0] COLOR2_RESET = 16'h1F00;
  localparam logic [15:0] COLOR3_RESET = 16'hE0FF;
  localparam logic [15:0] BACK_RESET   = 16'hC318;

  // An index past the last register; writes there must change nothing.
  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam logic [2:0] COLOR_REGS [bsm_pkg::REG_COUNT] =
    '{bsm_pkg::REG_SPRITE0, bsm_pkg::REG_SPRITE1, bsm_pkg::REG_SPRITE2,
      bsm_pkg::REG_SPRITE3, bsm_pkg::REG_BACKGROUND};

  localparam int DRAIN_CYCLES = SPRITES + 4;
  localparam int HOLD_CYCLES  = 80;
  localparam int LIMIT_NS     = 5_000_000;

  typedef enum {PALETTE_ZERO, PALETTE_ONES, PALETTE_RANDOM} palette_t;

  typedef struct {
    bsm_pkg::in_item_t  item;
    bit                 typed;
    bsm_pkg::out_item_t want;
  } stim_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  bsm_pkg::in_item_t          in_item;
  logic                       out_valid;
  logic                       out_stall;
  bsm_pkg::out_item_t         out_item;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [bsm_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  // Our own copy of the sprite positions and the color registers.
  int          pos_left [SPRITES];
  int          pos_top  [SPRITES];
  logic [15:0] sprite_rgb [4];
  logic [15:0] back_rgb;

  bsm_pkg::out_item_t pending_pixels [$];
  stim_row_t          directed_rows [$];
  int                 errors;
  bit                 steady;
  bit                 hold_request;
  bit                 hold_active;

  box_sprite_mover_and_compositor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // A coordinate past the far edge goes to 0, one below 0 goes to the last full box.
  function automatic int wrap_coord(input int pos, input int size);
    if (pos >= size) return 0;
    if (pos < 0) return size - EDGE_LEN;
    return pos;
  endfunction

  // Applies one item to the position copy; returns 1 with the pixel result for a query.
  function automatic bit overlay_predict(input bsm_pkg::in_item_t it,
                                         output bsm_pkg::out_item_t res);
    int px;
    int py;
    int l;
    int t;
    res.pixel_color     = back_rgb;
    res.covering_sprite = 3'(SPRITES);
    if (it.opcode == bsm_pkg::OP_MOVE) begin
      if (int'(it.sprite_id) < SPRITES) begin
        pos_left[it.sprite_id] =
          wrap_coord(pos_left[it.sprite_id] + int'($signed(it.delta_x)), SCR_W);
        pos_top[it.sprite_id] =
          wrap_coord(pos_top[it.sprite_id] + int'($signed(it.delta_y)), SCR_H);
      end
      return 1'b0;
    end
    px = int'(it.pixel_x);
    py = int'(it.pixel_y);
    if (px < SCR_W && py < SCR_H) begin
      // Later sprites are drawn on top, so the last hit wins.
      for (int i = 0; i < SPRITES; i++) begin
        l = pos_left[i];
        t = pos_top[i];
        if (px >= l && px < l + EDGE_LEN && py >= t && py < t + EDGE_LEN) begin
          res.pixel_color     = sprite_rgb[i % 4];
          res.covering_sprite = 3'(i);
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic void plan_row(input logic op, input int id, input int dx, input int dy,
                                   input int px, input int py, input bit typed,
                                   input logic [15:0] color, input int who);
    stim_row_t row;
    row.item.opcode          = op;
    row.item.sprite_id       = 2'(id);
    row.item.delta_x         = 8'(dx);
    row.item.delta_y         = 8'(dy);
    row.item.pixel_x         = 9'(px);
    row.item.pixel_y         = 9'(py);
    row.typed                = typed;
    row.want.pixel_color     = color;
    row.want.covering_sprite = 3'(who);
    directed_rows.push_back(row);
  endfunction

  // Queries mostly close to a sprite and the rest anywhere in the 9-bit range;
  // moves small or wide with equal chance.
  function automatic bsm_pkg::in_item_t random_item();
    bsm_pkg::in_item_t it;
    int id;
    it.opcode    = ($urandom_range(0, 99) < 40) ? bsm_pkg::OP_MOVE : bsm_pkg::OP_PIXEL;
    it.sprite_id = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 1) begin
      it.delta_x = 8'($urandom);
      it.delta_y = 8'($urandom);
    end else begin
      it.delta_x = 8'($urandom_range(0, 20) - 10);
      it.delta_y = 8'($urandom_range(0, 20) - 10);
    end
    if (it.opcode == bsm_pkg::OP_PIXEL && $urandom_range(0, 99) < 60) begin
      id = $urandom_range(0, SPRITES - 1);
      it.pixel_x = 9'(pos_left[id] + $urandom_range(0, EDGE_LEN + 3) - 2);
      it.pixel_y = 9'(pos_top[id] + $urandom_range(0, EDGE_LEN + 3) - 2);
    end else begin
      it.pixel_x = 9'($urandom);
      it.pixel_y = 9'($urandom);
    end
    return it;
  endfunction

  // Offers one item until it is taken, then records what it should produce.
  task automatic offer_item(input bsm_pkg::in_item_t it, input bit typed,
                            input bsm_pkg::out_item_t want);
    bsm_pkg::out_item_t res;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    if (overlay_predict(it, res)) pending_pixels.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // Random pause on the sending side, mostly none.
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (steady || r < 70) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else if (r < 98) n = $urandom_range(4, 10);
    else n = $urandom_range(15, 30);
    if (n > 0) begin
      in_valid <= 1'b0;
      in_item  <= random_item();
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) begin
      sender_gap();
      offer_item(random_item(), 1'b0, '0);
    end
  endtask

  // Stop sending and wait until the block has emptied out.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_color(input logic [2:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == bsm_pkg::REG_BACKGROUND) back_rgb = val;
    else if (idx < bsm_pkg::REG_BACKGROUND) sprite_rgb[idx[1:0]] = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_check(input logic [2:0] idx, input logic [15:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, want}) begin
      $display("%0t: register %0d read mismatch, expected %h, got %h",
               $time, idx, {16'h0000, want}, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Loads a new palette while the block is idle, pokes the unused index and reads back.
  task automatic recolor(input palette_t mode);
    logic [15:0] val;
    settle();
    for (int k = 0; k < bsm_pkg::REG_COUNT; k++) begin
      case (mode)
        PALETTE_ZERO: val = 16'h0000;
        PALETTE_ONES: val = 16'hFFFF;
        default:      val = 16'($urandom);
      endcase
      write_color(COLOR_REGS[k], val);
    end
    write_color(REG_UNUSED, 16'($urandom));
    for (int k = 0; k < bsm_pkg::REG_COUNT; k++) begin
      read_check(COLOR_REGS[k], (COLOR_REGS[k] == bsm_pkg::REG_BACKGROUND) ?
                 back_rgb : sprite_rgb[COLOR_REGS[k][1:0]]);
    end
  endtask

  // Receiver: random stall runs, or one long hold when asked for.
  initial begin
    int r;
    int len;
    bit stall_val;
    out_stall   = 1'b0;
    hold_active = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        @(negedge clk);
        out_stall   <= 1'b1;
        hold_active  = 1'b1;
        hold_request = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_active  = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (steady) begin
          stall_val = 1'b0;
          len = 1;
        end else if (r < 55) begin
          stall_val = 1'b0;
          len = $urandom_range(1, 20);
        end else if (r < 88) begin
          stall_val = 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 97) begin
          stall_val = 1'b1;
          len = $urandom_range(4, 10);
        end else begin
          stall_val = 1'b1;
          len = $urandom_range(20, 40);
        end
        @(negedge clk);
        out_stall <= stall_val;
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  // Each result taken is matched against the oldest pixel still owed.
  always @(posedge clk) begin : check_results
    bsm_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel result, expected none, got color %h sprite %0d",
                 $time, out_item.pixel_color, out_item.covering_sprite);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_item.pixel_color !== want.pixel_color) begin
          $display("%0t: pixel color mismatch, expected %h, got %h",
                   $time, want.pixel_color, out_item.pixel_color);
          errors++;
        end
        if (out_item.covering_sprite !== want.covering_sprite) begin
          $display("%0t: covering sprite mismatch, expected %0d, got %0d",
                   $time, want.covering_sprite, out_item.covering_sprite);
          errors++;
        end
      end
    end
  end

  initial begin
    errors       = 0;
    steady       = 1'b0;
    hold_request = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pos_left     = '{50, 400, 220, 100};
    pos_top      = '{60, 60, 20, 200};
    sprite_rgb   = '{COLOR0_RESET, COLOR1_RESET, COLOR2_RESET, COLOR3_RESET};
    back_rgb     = BACK_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset layout: corners of each box, just outside them, and off-screen pixels.
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 1'b1, BACK_RESET, SPRITES);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 50, 60, 1'b1, COLOR0_RESET, 0);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 79, 89, 1'b1, COLOR0_RESET, 0);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 80, 89, 1'b1, BACK_RESET, SPRITES);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 400, 60, 1'b1, COLOR1_RESET, 1);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 220, 20, 1'b1, COLOR2_RESET, 2);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 129, 229, 1'b1, COLOR3_RESET, 3);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 479, 319, 1'b1, BACK_RESET, SPRITES);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 480, 60, 1'b1, BACK_RESET, SPRITES);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 50, 320, 1'b1, BACK_RESET, SPRITES);
    plan_row(bsm_pkg::OP_PIXEL, 3, 127, -128, 511, 511, 1'b1, BACK_RESET, SPRITES);
    // Largest steps both ways without wrapping.
    plan_row(bsm_pkg::OP_MOVE, 0, 127, 127, 511, 511, 1'b0, '0, 0);
    plan_row(bsm_pkg::OP_MOVE, 0, -128, -128, 0, 0, 1'b0, '0, 0);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 49, 59, 1'b0, '0, 0);
    // Wrap past the right edge, then below zero on both axes into the far corner.
    plan_row(bsm_pkg::OP_MOVE, 1, 127, 0, 0, 0, 1'b0, '0, 0);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 0, 60, 1'b0, '0, 0);
    plan_row(bsm_pkg::OP_MOVE, 1, -128, -128, 0, 0, 1'b0, '0, 0);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 479, 319, 1'b0, '0, 0);
    // Stack sprite 3 on sprite 2; the higher index must win.
    plan_row(bsm_pkg::OP_MOVE, 3, 120, -128, 0, 0, 1'b0, '0, 0);
    plan_row(bsm_pkg::OP_MOVE, 3, 0, -52, 0, 0, 1'b0, '0, 0);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 225, 25, 1'b0, '0, 0);
    // Sprite 2 moved down short of the bottom edge, then a wrap past the bottom.
    plan_row(bsm_pkg::OP_MOVE, 2, 0, 127, 0, 0, 1'b0, '0, 0);
    plan_row(bsm_pkg::OP_MOVE, 2, 0, 127, 0, 0, 1'b0, '0, 0);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 225, 319, 1'b0, '0, 0);
    plan_row(bsm_pkg::OP_MOVE, 2, 0, 127, 0, 0, 1'b0, '0, 0);
    plan_row(bsm_pkg::OP_PIXEL, 0, 0, 0, 220, 0, 1'b0, '0, 0);

    foreach (directed_rows[k]) begin
      sender_gap();
      offer_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
    end

    recolor(PALETTE_RANDOM);
    run_random(220);

    // Receiver holds off while the sender keeps pushing, so the input backs up.
    in_valid <= 1'b0;
    hold_request = 1'b1;
    wait (hold_active);
    steady = 1'b1;
    run_random(40);
    steady = 1'b0;

    recolor(PALETTE_ZERO);
    steady = 1'b1;
    run_random(150);
    steady = 1'b0;

    recolor(PALETTE_ONES);
    run_random(200);

    recolor(PALETTE_RANDOM);
    run_random(240);

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
